### sv/bitmap_to_pixel_expander_assert.svh
// Assertion macros used by the expander's back-end RTL file, bpe_expander.sv.
`ifndef BITMAP_TO_PIXEL_EXPANDER_ASSERT_SVH
`define BITMAP_TO_PIXEL_EXPANDER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/bpe_pkg.sv
`timescale 1ns / 1ps
package bpe_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int MAX_SIDE_DEF   = 255;
  localparam int BYTE_W         = 8;
  localparam int SIDE_W         = 8;
  localparam int BIT_IDX_W      = 3;
  localparam int CFG_IDX_W      = 3;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [SIDE_W-1:0] WIDTH_RESET  = 8'd8;
  localparam logic [SIDE_W-1:0] HEIGHT_RESET = 8'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X     = 3'd0,
    REG_ORIGIN_Y     = 3'd1,
    REG_IMAGE_WIDTH  = 3'd2,
    REG_IMAGE_HEIGHT = 3'd3,
    REG_HSCAN        = 3'd4,
    REG_LSB_FIRST    = 3'd5
  } bpe_reg_e;

  // Scan setup shared between the register file and the back end.
  typedef struct packed {
    logic [SIDE_W-1:0] image_width;
    logic [SIDE_W-1:0] image_height;
    logic              horizontal_scan;
    logic              lsb_first;
  } bpe_scan_cfg_t;

endpackage

### sv/bpe_byte_queue.sv
`timescale 1ns / 1ps
module bpe_byte_queue
  import bpe_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [BYTE_W-1:0] wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [BYTE_W-1:0] rdata_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [BYTE_W-1:0] mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

### sv/bpe_expander.sv
`timescale 1ns / 1ps
`include "bitmap_to_pixel_expander_assert.svh"
module bpe_expander
  import bpe_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int MAX_SIDE   = MAX_SIDE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bpe_scan_cfg_t         cfg_i,
  input  logic [COORD_BITS-1:0] origin_x_i,
  input  logic [COORD_BITS-1:0] origin_y_i,
  input  logic                  byte_valid_i,
  input  logic [BYTE_W-1:0]     byte_i,
  output logic                  byte_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_pop_i,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output logic                  pixel_on_o,
  output logic                  last_of_byte_o,
  output logic                  image_done_o
);

  localparam int CNT_W = $clog2(MAX_SIDE + 1);
  localparam logic [SIDE_W-1:0] MAX_SIDE_V = SIDE_W'(MAX_SIDE);

  logic [CNT_W-1:0]     minor_q, minor_d, major_q, major_d;
  logic [BIT_IDX_W-1:0] bit_q, bit_d;
  logic                 out_valid_q, out_valid_d;
  logic [COORD_BITS-1:0] px_q, px_d, py_q, py_d;
  logic                 on_q, on_d, last_q, last_d, done_q, done_d;

  logic [CNT_W-1:0] w_lim, h_lim, minor_lim, major_lim, col, row;
  logic             advance, minor_wrap, major_wrap, done, last;

  function automatic logic [CNT_W-1:0] side_limit(input logic [SIDE_W-1:0] v);
    if (v == '0) begin
      return CNT_W'(1);
    end
    if (v > MAX_SIDE_V) begin
      return CNT_W'(MAX_SIDE_V);
    end
    return CNT_W'(v);
  endfunction

  // A pixel moves into the output register when it is empty or being drained.
  assign advance    = byte_valid_i && (!out_valid_q || out_pop_i);
  assign byte_pop_o = advance && last;

  always_comb begin
    w_lim      = side_limit(cfg_i.image_width);
    h_lim      = side_limit(cfg_i.image_height);
    minor_lim  = cfg_i.horizontal_scan ? w_lim : h_lim;
    major_lim  = cfg_i.horizontal_scan ? h_lim : w_lim;
    col        = cfg_i.horizontal_scan ? minor_q : major_q;
    row        = cfg_i.horizontal_scan ? major_q : minor_q;
    minor_wrap = ({1'b0, minor_q} + 1'b1) >= {1'b0, minor_lim};
    major_wrap = ({1'b0, major_q} + 1'b1) >= {1'b0, major_lim};
    done       = minor_wrap && major_wrap;
    last       = done || (bit_q == '1);

    minor_d     = minor_q;
    major_d     = major_q;
    bit_d       = bit_q;
    out_valid_d = out_valid_q && !out_pop_i;
    px_d        = px_q;
    py_d        = py_q;
    on_d        = on_q;
    last_d      = last_q;
    done_d      = done_q;

    if (advance) begin
      if (minor_wrap) begin
        minor_d = '0;
        major_d = major_wrap ? '0 : major_q + 1'b1;
      end else begin
        minor_d = minor_q + 1'b1;
      end
      bit_d       = last ? '0 : bit_q + 1'b1;
      out_valid_d = 1'b1;
      px_d        = origin_x_i + COORD_BITS'(col);
      py_d        = origin_y_i + COORD_BITS'(row);
      on_d        = cfg_i.lsb_first ? byte_i[bit_q] : byte_i[BYTE_W-1-int'(bit_q)];
      last_d      = last;
      done_d      = done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      minor_q     <= '0;
      major_q     <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      minor_q     <= minor_d;
      major_q     <= major_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q   <= px_d;
    py_q   <= py_d;
    on_q   <= on_d;
    last_q <= last_d;
    done_q <= done_d;
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_x_o      = px_q;
  assign pixel_y_o      = py_q;
  assign pixel_on_o     = on_q;
  assign last_of_byte_o = last_q;
  assign image_done_o   = done_q;

  `BPE_ASSERT_SAME(a_done_ends_byte, clk_i, rst_ni, out_valid_q && done_q, last_q)
  `BPE_ASSERT_NEXT(a_done_clears_scan, clk_i, rst_ni, advance && done,
                   minor_q == '0 && major_q == '0)
  `BPE_ASSERT_NEXT(a_last_restarts_bit, clk_i, rst_ni, advance && last, bit_q == '0)

endmodule

### sv/bitmap_to_pixel_expander.sv
// A pushed byte waits in the byte queue; its pixels then pass the result register to the ports.
// One pixel per cycle unless the queue empties or pop stalls; an image end cuts a byte short.
// The rate is set by the single pixel stage in the back end, one bit per cycle.
// Reset (rst_ni low, asynchronous): queue and result register empty, scan counters zero,
// registers at origin 0/0, 8x8 image, column-major scan, bit 0 first.
`timescale 1ns / 1ps
module bitmap_to_pixel_expander
  import bpe_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int MAX_SIDE   = MAX_SIDE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Image byte input, queue style.
  input  logic                  push,
  output logic                  full,
  input  logic [BYTE_W-1:0]     image_byte_i,
  // Pixel result output, queue style.
  output logic                  empty,
  input  logic                  pop,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output logic                  pixel_on_o,
  output logic                  last_of_byte_o,
  output logic                  image_done_o,
  // Register write channel.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [COORD_BITS-1:0] cfg_data_i
);

  // Register file. Writes are registered directly, so the channel is always ready.
  // Indexes beyond the list are accepted and dropped.
  logic [COORD_BITS-1:0] origin_x_q, origin_y_q;
  bpe_scan_cfg_t         scan_cfg_q;
  logic                  cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q                 <= '0;
      origin_y_q                 <= '0;
      scan_cfg_q.image_width     <= WIDTH_RESET;
      scan_cfg_q.image_height    <= HEIGHT_RESET;
      scan_cfg_q.horizontal_scan <= 1'b0;
      scan_cfg_q.lsb_first       <= 1'b1;
    end else if (cfg_we) begin
      case (bpe_reg_e'(cfg_index_i))
        REG_ORIGIN_X: begin
          origin_x_q <= cfg_data_i;
        end
        REG_ORIGIN_Y: begin
          origin_y_q <= cfg_data_i;
        end
        REG_IMAGE_WIDTH: begin
          scan_cfg_q.image_width <= cfg_data_i[SIDE_W-1:0];
        end
        REG_IMAGE_HEIGHT: begin
          scan_cfg_q.image_height <= cfg_data_i[SIDE_W-1:0];
        end
        REG_HSCAN: begin
          scan_cfg_q.horizontal_scan <= cfg_data_i[0];
        end
        REG_LSB_FIRST: begin
          scan_cfg_q.lsb_first <= cfg_data_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  // Front end: a short byte queue. It keeps taking words while the back end
  // is still expanding an earlier byte, so the two sides stall independently.
  logic              q_valid, q_pop;
  logic [BYTE_W-1:0] q_byte;

  bpe_byte_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (image_byte_i),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_byte)
  );

  // Back end: walks the bits of the byte at the head of the queue, one pixel per
  // cycle unless the consumer stalls, and releases the byte with its last pixel.
  // Its result register holds a pixel while the consumer stalls.
  logic out_valid;

  bpe_expander #(
    .COORD_BITS (COORD_BITS),
    .MAX_SIDE   (MAX_SIDE)
  ) u_expander (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (scan_cfg_q),
    .origin_x_i     (origin_x_q),
    .origin_y_i     (origin_y_q),
    .byte_valid_i   (q_valid),
    .byte_i         (q_byte),
    .byte_pop_o     (q_pop),
    .out_valid_o    (out_valid),
    .out_pop_i      (pop),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .pixel_on_o     (pixel_on_o),
    .last_of_byte_o (last_of_byte_o),
    .image_done_o   (image_done_o)
  );

  assign empty = !out_valid;

endmodule

### bench/bitmap_to_pixel_expander_checker.sv
`timescale 1ns / 1ps
module bitmap_to_pixel_expander_checker
  import bpe_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  logic                      full_i,
  input  logic [BYTE_W-1:0]         image_byte_i,
  input  logic                      empty_i,
  input  logic                      pop_i,
  input  logic [COORD_BITS_DEF-1:0] pixel_x_i,
  input  logic [COORD_BITS_DEF-1:0] pixel_y_i,
  input  logic                      pixel_on_i,
  input  logic                      last_of_byte_i,
  input  logic                      image_done_i,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [COORD_BITS_DEF-1:0] cfg_data_i,
  output int                        mismatch_cnt_o,
  output int                        pending_o,
  output int                        pixels_checked_o,
  output int                        images_done_o
);

  localparam int CW        = COORD_BITS_DEF;
  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic          on;
    logic          last;
    logic          done;
  } pixel_word_t;

  pixel_word_t       pixel_q[$];
  pixel_word_t       want;
  logic [CW-1:0]     org_x;
  logic [CW-1:0]     org_y;
  logic [SIDE_W-1:0] img_w;
  logic [SIDE_W-1:0] img_h;
  logic              hscan;
  logic              lsb_first;
  logic [SIDE_W-1:0] fast_cnt;
  logic [SIDE_W-1:0] slow_cnt;

  task automatic flag_mismatch(input string msg);
    if (mismatch_cnt_o < PRINT_CAP) begin
      $display("%0d ns: mismatch: %s", $time, msg);
    end
    mismatch_cnt_o++;
  endtask

  // A side of zero behaves as one.
  function automatic int side_of(input logic [SIDE_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MAX_SIDE_DEF) return MAX_SIDE_DEF;
    return int'(v);
  endfunction

  // Expands one image byte into the pixel words it must produce.
  task automatic expand_byte(input logic [BYTE_W-1:0] b);
    int            fast_lim;
    int            slow_lim;
    int            i;
    logic          done;
    logic [CW-1:0] col;
    logic [CW-1:0] row;
    pixel_word_t   p;
    fast_lim = hscan ? side_of(img_w) : side_of(img_h);
    slow_lim = hscan ? side_of(img_h) : side_of(img_w);
    i = 0;
    done = 1'b0;
    while (i < BYTE_W && !done) begin
      col = hscan ? fast_cnt : slow_cnt;
      row = hscan ? slow_cnt : fast_cnt;
      if (int'(fast_cnt) + 1 >= fast_lim) begin
        fast_cnt = '0;
        if (int'(slow_cnt) + 1 >= slow_lim) begin
          slow_cnt = '0;
          done = 1'b1;
        end else begin
          slow_cnt = slow_cnt + 1'b1;
        end
      end else begin
        fast_cnt = fast_cnt + 1'b1;
      end
      p.x    = org_x + col;
      p.y    = org_y + row;
      p.on   = lsb_first ? b[i] : b[BYTE_W-1-i];
      p.last = done || (i == BYTE_W - 1);
      p.done = done;
      pixel_q.push_back(p);
      i++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_q.delete();
      org_x     <= '0;
      org_y     <= '0;
      img_w     <= WIDTH_RESET;
      img_h     <= HEIGHT_RESET;
      hscan     <= 1'b0;
      lsb_first <= 1'b1;
      fast_cnt  <= '0;
      slow_cnt  <= '0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_ORIGIN_X:     org_x = cfg_data_i;
          REG_ORIGIN_Y:     org_y = cfg_data_i;
          REG_IMAGE_WIDTH:  img_w = cfg_data_i[SIDE_W-1:0];
          REG_IMAGE_HEIGHT: img_h = cfg_data_i[SIDE_W-1:0];
          REG_HSCAN:        hscan = cfg_data_i[0];
          REG_LSB_FIRST:    lsb_first = cfg_data_i[0];
          default: ;
        endcase
      end
      if (push_i && !full_i) begin
        expand_byte(image_byte_i);
      end
      if (pop_i && !empty_i) begin
        if (pixel_q.size() == 0) begin
          flag_mismatch($sformatf("pixel word x=%0d y=%0d on=%0b with nothing expected",
                                  pixel_x_i, pixel_y_i, pixel_on_i));
        end else begin
          want = pixel_q.pop_front();
          if (pixel_x_i !== want.x || pixel_y_i !== want.y || pixel_on_i !== want.on ||
              last_of_byte_i !== want.last || image_done_i !== want.done) begin
            flag_mismatch($sformatf(
              "got x=%0d y=%0d on=%0b last=%0b done=%0b, want x=%0d y=%0d on=%0b last=%0b done=%0b",
              pixel_x_i, pixel_y_i, pixel_on_i, last_of_byte_i, image_done_i,
              want.x, want.y, want.on, want.last, want.done));
          end
          pixels_checked_o++;
          if (want.done) images_done_o++;
        end
      end
      pending_o <= pixel_q.size();
    end
  end

endmodule

### bench/tb_bitmap_to_pixel_expander.sv
`timescale 1ns / 1ps
module tb_bitmap_to_pixel_expander;
  import bpe_pkg::*;

  localparam int CW            = COORD_BITS_DEF;
  localparam int RESET_CYCLES  = 11;
  // Margin after the last expected pixel word is taken, before a register write.
  localparam int HOLD_OFF      = 3;
  // Cycles to watch the result side after the last expected word has arrived.
  localparam int DRAIN_CYCLES  = 16;
  // A correct run always has a handshake on some channel well within this bound,
  // so the bound is far beyond any legal pause.
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_BYTES   = 30;

  // Register indexes that the block does not decode; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  push;
  logic                  full;
  logic [BYTE_W-1:0]     image_byte_i;
  logic                  empty;
  logic                  pop;
  logic [CW-1:0]         pixel_x_o;
  logic [CW-1:0]         pixel_y_o;
  logic                  pixel_on_o;
  logic                  last_of_byte_o;
  logic                  image_done_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CW-1:0]         cfg_data_i;

  int mismatch_cnt;
  int pixels_pending;
  int pixels_checked;
  int images_done;
  int bytes_sent;
  int reg_writes;
  int settings_used;
  // Set for the closing part of the run, where neither side idles.
  bit no_idle;

  bitmap_to_pixel_expander i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .image_byte_i   (image_byte_i),
    .empty          (empty),
    .pop            (pop),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .pixel_on_o     (pixel_on_o),
    .last_of_byte_o (last_of_byte_o),
    .image_done_o   (image_done_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  bitmap_to_pixel_expander_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .full_i           (full),
    .image_byte_i     (image_byte_i),
    .empty_i          (empty),
    .pop_i            (pop),
    .pixel_x_i        (pixel_x_o),
    .pixel_y_i        (pixel_y_o),
    .pixel_on_i       (pixel_on_o),
    .last_of_byte_i   (last_of_byte_o),
    .image_done_i     (image_done_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_cnt_o   (mismatch_cnt),
    .pending_o        (pixels_pending),
    .pixels_checked_o (pixels_checked),
    .images_done_o    (images_done)
  );

  // 8 ns clock.
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Sends one image byte. The caller is always at a falling edge, and so is the task
  // when it returns. Push is left high so that back-to-back words need no second
  // assignment in the same time step; whoever stops sending lowers it.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    push         <= 1'b1;
    image_byte_i <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  // Writes one register. Like send_byte, it leaves valid high; the caller lowers it
  // once the whole batch of writes is done.
  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    reg_writes++;
  endtask

  // Stops sending and waits until every predicted pixel word has been taken, so the
  // block is idle before registers change. This is also the pause in which the sender
  // holds back until the result side has caught up completely.
  task automatic settle();
    push <= 1'b0;
    @(negedge clk_i);
    while (pixels_pending != 0) @(negedge clk_i);
    repeat (HOLD_OFF) @(negedge clk_i);
    settings_used++;
  endtask

  // Image sides lean toward small values so that images finish often, with the
  // zero case and the largest side mixed in.
  function automatic logic [SIDE_W-1:0] pick_side();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return SIDE_W'(MAX_SIDE_DEF);
      2:       return SIDE_W'(1);
      default: return SIDE_W'($urandom_range(2, 12));
    endcase
  endfunction

  function automatic logic [CW-1:0] pick_origin();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return CW'($urandom_range(0, 65535));
    endcase
  endfunction

  // Rewrites a random subset of the registers, the undecoded indexes included. Upper
  // data bits are random even where the block only keeps the low ones.
  task automatic random_setting();
    logic [CW-1:0] data;
    for (int idx = 0; idx < (1 << CFG_IDX_W); idx++) begin
      if ($urandom_range(0, 1) == 1) begin
        data = CW'($urandom_range(0, 65535));
        case (idx)
          REG_ORIGIN_X, REG_ORIGIN_Y:        data = pick_origin();
          REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT: data[SIDE_W-1:0] = pick_side();
          default: ;
        endcase
        program_reg(CFG_IDX_W'(idx), data);
      end
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Result side: pop is mostly high, with random stall bursts until the closing part of
  // the run.
  initial begin
    int stall_left;
    stall_left = 0;
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        stall_left = $urandom_range(0, 5);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run if no channel moves a word for too long.
  initial begin
    int quiet_run;
    quiet_run = 0;
    @(posedge rst_ni);
    while (quiet_run < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
        quiet_run = 0;
      end else begin
        quiet_run++;
      end
    end
    $display("Timeout: no word moved for %0d cycles, %0d pixel words still expected.",
             STALL_LIMIT, pixels_pending);
    $display("[bitmap_to_pixel_expander] ERROR");
    $finish;
  end

  initial begin
    rst_ni       = 1'b0;
    push         = 1'b0;
    image_byte_i = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = REG_ORIGIN_X;
    cfg_data_i   = '0;
    no_idle      = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset setting: an 8x8 image, column-major, bit 0 first. Eight bytes make exactly
    // one image, so the last pixel of the eighth byte must carry image_done. The bytes
    // cover all-zero, all-one, each single end bit and the alternating patterns.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(8'h80);
    send_byte(8'hAA);
    send_byte(8'h55);
    send_byte(8'h0F);
    send_byte(8'hF0);

    // Every register, the undecoded indexes too. A width of zero acts as one, so the
    // image is one column by three rows: each byte ends an image after three pixels and
    // its remaining five bits are dropped. The origins sit at the top of the coordinate
    // range so the row offsets wrap past zero. Bit 7 is taken first.
    settle();
    program_reg(REG_ORIGIN_X, 16'hFFFF);
    program_reg(REG_ORIGIN_Y, 16'hFFFE);
    program_reg(REG_IMAGE_WIDTH, 16'hFF00);
    program_reg(REG_IMAGE_HEIGHT, 16'h0003);
    program_reg(REG_HSCAN, 16'h0001);
    program_reg(REG_LSB_FIRST, 16'hFFFE);
    program_reg(REG_SPARE_6, 16'h1234);
    program_reg(REG_SPARE_7, 16'hFFFF);
    cfg_valid_i <= 1'b0;
    send_byte(8'hA5);
    send_byte(8'h5A);

    // Largest image, column-major: the row counter climbs to sixteen.
    settle();
    program_reg(REG_ORIGIN_X, 16'h0000);
    program_reg(REG_ORIGIN_Y, 16'h0000);
    program_reg(REG_IMAGE_WIDTH, 16'h00FF);
    program_reg(REG_IMAGE_HEIGHT, 16'h00FF);
    program_reg(REG_HSCAN, 16'h0000);
    cfg_valid_i <= 1'b0;
    send_byte(8'h3C);
    send_byte(8'hC3);

    // Shrink the image in the middle of it: the counters stay where they were, beyond
    // the new limit, so the next pixel still lands at row sixteen before the wrap.
    settle();
    program_reg(REG_IMAGE_WIDTH, 16'h0003);
    program_reg(REG_IMAGE_HEIGHT, 16'h0003);
    cfg_valid_i <= 1'b0;
    send_byte(8'h96);
    send_byte(8'h69);

    // Flip the scan order mid-image: the two counters swap meaning from here on.
    settle();
    program_reg(REG_HSCAN, 16'h8001);
    cfg_valid_i <= 1'b0;
    send_byte(8'hE7);
    send_byte(8'h18);

    // One-pixel image: every byte yields exactly one word that ends the image.
    settle();
    program_reg(REG_IMAGE_WIDTH, 16'h0001);
    program_reg(REG_IMAGE_HEIGHT, 16'h0001);
    program_reg(REG_LSB_FIRST, 16'h0001);
    program_reg(REG_ORIGIN_X, 16'h8000);
    cfg_valid_i <= 1'b0;
    send_byte(8'h01);
    send_byte(8'hFE);
    send_byte(8'hFF);

    // Largest image row-major at the highest origin: the x coordinate wraps past zero.
    settle();
    program_reg(REG_IMAGE_WIDTH, 16'h00FF);
    program_reg(REG_IMAGE_HEIGHT, 16'h00FF);
    program_reg(REG_ORIGIN_X, 16'hFFFF);
    program_reg(REG_ORIGIN_Y, 16'hFFFF);
    cfg_valid_i <= 1'b0;
    send_byte(8'h81);
    send_byte(8'h7E);

    // Random part. Phases do not line up with image boundaries, so most register
    // changes land in the middle of an image. The last phase runs with no idling.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      random_setting();
      if (phase == RANDOM_PHASES - 1) no_idle = 1'b1;
      for (int n = 0; n < PHASE_BYTES; n++) begin
        case ($urandom_range(0, 7))
          0:       send_byte('0);
          1:       send_byte('1);
          default: send_byte(BYTE_W'($urandom_range(0, 255)));
        endcase
      end
    end

    // Drain: wait for every expected word, then keep popping a while longer so that
    // any extra word from the block is caught. The watchdog bounds both waits.
    push <= 1'b0;
    while (pixels_pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Sent %0d image bytes under %0d register settings with %0d register writes.",
             bytes_sent, settings_used, reg_writes);
    $display("Checked %0d pixel words over %0d finished images; %0d mismatches.",
             pixels_checked, images_done, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("[bitmap_to_pixel_expander] OK");
    end else begin
      $display("[bitmap_to_pixel_expander] ERROR");
    end
    $finish;
  end

endmodule
